FILE: rtl/core/bse_pkg.sv
package bse_pkg;

  // Request codes carried in req_type.
  localparam logic [1:0] REQ_START   = 2'd0;
  localparam logic [1:0] REQ_PALETTE = 2'd1;
  localparam logic [1:0] REQ_PIXEL   = 2'd2;

  // Image mode codes.
  localparam logic [1:0] MODE_MONO       = 2'd0;
  localparam logic [1:0] MODE_INDEXED    = 2'd1;
  localparam logic [1:0] MODE_TRUE_COLOR = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_IMAGE_MODE      = 3'd0;
  localparam logic [2:0] REG_PALETTE_COUNT   = 3'd1;
  localparam logic [2:0] REG_IMG_WIDTH       = 3'd2;
  localparam logic [2:0] REG_IMG_HEIGHT      = 3'd3;
  localparam logic [2:0] REG_ROW_BYTES       = 3'd4;
  localparam logic [2:0] REG_DEFAULT_PALETTE = 3'd5;

  localparam int BSE_DIM_BITS  = 16;
  localparam int BSE_JOB_DEPTH = 4;
  localparam int BSE_ADDR_W    = 5;

  // Last header byte index, without and with the built-in palette.
  localparam logic [5:0] HDR_LAST_PLAIN = 6'd53;
  localparam logic [5:0] HDR_LAST_PAL   = 6'd61;

  typedef enum logic [1:0] {
    BPP_1,
    BPP_4,
    BPP_8,
    BPP_24
  } bpp_t;

  typedef enum logic {
    JOB_HEADER,
    JOB_DATA
  } job_kind_t;

  // Live configuration as seen by the datapath.
  typedef struct packed {
    logic [1:0]  image_mode;
    logic [8:0]  palette_count;
    logic [15:0] img_width;
    logic [15:0] img_height;
    logic [17:0] row_bytes;
    logic        default_palette;
  } cfg_t;

  // One unit of output work: data bytes first, then zero padding.
  typedef struct packed {
    job_kind_t   kind;
    logic [23:0] data;
    logic [1:0]  nbytes;
    logic [1:0]  pad;
    logic        done;
  } job_t;

  function automatic bpp_t get_bpp(input logic [1:0] mode, input logic [8:0] pal_cnt);
    bpp_t b;
    b = BPP_24;
    if (mode == MODE_MONO) begin
      b = BPP_1;
    end else if (mode == MODE_INDEXED) begin
      b = (pal_cnt <= 9'd16) ? BPP_4 : BPP_8;
    end
    return b;
  endfunction

endpackage

FILE: rtl/core/bse_in_if.sv
interface bse_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [23:0] item_value;

  modport source (output valid, output req_type, output item_value, input ready);
  modport sink   (input valid, input req_type, input item_value, output ready);
endinterface

FILE: rtl/core/bse_out_if.sv
interface bse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       file_done;

  modport source (output valid, output out_byte, output run_last, output file_done,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input file_done,
                  output ready);
endinterface

FILE: rtl/core/bse_regs.sv
module bse_regs
  import bse_pkg::*;
#(
  parameter int DIM_BITS = BSE_DIM_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [BSE_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [1:0]          image_mode_r;
  logic [8:0]          palette_count_r;
  logic [DIM_BITS-1:0] img_width_r;
  logic [DIM_BITS-1:0] img_height_r;
  logic [17:0]         row_bytes_r;
  logic                default_palette_r;
  logic [2:0]          reg_idx;
  logic                wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_mode_r      <= MODE_TRUE_COLOR;
      palette_count_r   <= 9'd0;
      img_width_r       <= DIM_BITS'(1);
      img_height_r      <= DIM_BITS'(1);
      row_bytes_r       <= 18'd4;
      default_palette_r <= 1'b1;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_IMAGE_MODE:      image_mode_r      <= pwdata[1:0];
        REG_PALETTE_COUNT:   palette_count_r   <= pwdata[8:0];
        REG_IMG_WIDTH:       img_width_r       <= pwdata[DIM_BITS-1:0];
        REG_IMG_HEIGHT:      img_height_r      <= pwdata[DIM_BITS-1:0];
        REG_ROW_BYTES:       row_bytes_r       <= pwdata[17:0];
        REG_DEFAULT_PALETTE: default_palette_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    unique case (reg_idx)
      REG_IMAGE_MODE:      prdata = 32'(image_mode_r);
      REG_PALETTE_COUNT:   prdata = 32'(palette_count_r);
      REG_IMG_WIDTH:       prdata = 32'(img_width_r);
      REG_IMG_HEIGHT:      prdata = 32'(img_height_r);
      REG_ROW_BYTES:       prdata = 32'(row_bytes_r);
      REG_DEFAULT_PALETTE: prdata = 32'(default_palette_r);
      default:             prdata = 32'd0;
    endcase
  end

  always_comb begin
    cfg.image_mode      = image_mode_r;
    cfg.palette_count   = palette_count_r;
    cfg.img_width       = 16'(img_width_r);
    cfg.img_height      = 16'(img_height_r);
    cfg.row_bytes       = row_bytes_r;
    cfg.default_palette = default_palette_r;
  end

endmodule

FILE: rtl/core/bse_front.sv
module bse_front
  import bse_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  cfg_t   cfg,
  bse_in_if.sink in_chan,
  input  logic   job_full,
  output logic   job_push,
  output job_t   job
);

  logic [17:0] column_count_r, column_count_nxt;
  logic [15:0] rows_left_r, rows_left_nxt;
  logic [3:0]  held_nibble_r, held_nibble_nxt;
  logic        nibble_pending_r, nibble_pending_nxt;

  logic        accept;
  bpp_t        bpp;
  logic [17:0] col_inc;
  logic [17:0] row_len;
  logic        row_end;
  logic [16:0] width_p1;
  logic [3:0]  nib;
  logic [23:0] v;

  assign in_chan.ready = !job_full;
  assign accept        = in_chan.valid && !job_full;
  assign v             = in_chan.item_value;
  assign nib           = v[3:0];
  assign bpp           = get_bpp(cfg.image_mode, cfg.palette_count);
  assign col_inc       = column_count_r + 18'd1;
  assign row_len       = (bpp == BPP_1) ? cfg.row_bytes : 18'(cfg.img_width);
  assign row_end       = (col_inc >= row_len);
  assign width_p1      = 17'(cfg.img_width) + 17'd1;

  // Classify the transaction, update the row state and build the job.
  always_comb begin
    column_count_nxt   = column_count_r;
    rows_left_nxt      = rows_left_r;
    held_nibble_nxt    = held_nibble_r;
    nibble_pending_nxt = nibble_pending_r;
    job_push           = 1'b0;
    job.kind           = JOB_DATA;
    job.data           = v;
    job.nbytes         = 2'd0;
    job.pad            = 2'd0;
    job.done           = 1'b0;
    if (accept) begin
      priority case (in_chan.req_type)
        REQ_START: begin
          job_push           = 1'b1;
          job.kind           = JOB_HEADER;
          column_count_nxt   = 18'd0;
          rows_left_nxt      = cfg.img_height;
          held_nibble_nxt    = 4'd0;
          nibble_pending_nxt = 1'b0;
        end
        REQ_PALETTE: begin
          // Blue, green, red, then one zero byte.
          job_push   = 1'b1;
          job.nbytes = 2'd3;
          job.pad    = 2'd1;
        end
        REQ_PIXEL: begin
          column_count_nxt = col_inc;
          unique case (bpp)
            BPP_24: begin
              job.nbytes = 2'd3;
              job.pad    = cfg.img_width[1:0];
            end
            BPP_8: begin
              job.nbytes = 2'd1;
              job.pad    = 2'd0 - cfg.img_width[1:0];
            end
            BPP_1: begin
              job.nbytes = 2'd1;
              job.pad    = 2'd0 - cfg.row_bytes[1:0];
            end
            BPP_4: begin
              job.pad = 2'd0 - width_p1[2:1];
              if (nibble_pending_r) begin
                job.nbytes         = 2'd1;
                job.data           = {16'd0, held_nibble_r, nib};
                held_nibble_nxt    = 4'd0;
                nibble_pending_nxt = 1'b0;
              end else if (row_end) begin
                // A lone nibble closes the row in the high half.
                job.nbytes         = 2'd1;
                job.data           = {16'd0, nib, 4'd0};
                held_nibble_nxt    = 4'd0;
                nibble_pending_nxt = 1'b0;
              end else begin
                held_nibble_nxt    = nib;
                nibble_pending_nxt = 1'b1;
              end
            end
            default: ;
          endcase
          if (row_end) begin
            column_count_nxt = 18'd0;
            if (rows_left_r != 16'd0) begin
              rows_left_nxt = rows_left_r - 16'd1;
              job.done      = (rows_left_r == 16'd1);
            end
          end else begin
            job.pad = 2'd0;
          end
          job_push = (job.nbytes != 2'd0);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r   <= 18'd0;
      rows_left_r      <= 16'd0;
      held_nibble_r    <= 4'd0;
      nibble_pending_r <= 1'b0;
    end else begin
      column_count_r   <= column_count_nxt;
      rows_left_r      <= rows_left_nxt;
      held_nibble_r    <= held_nibble_nxt;
      nibble_pending_r <= nibble_pending_nxt;
    end
  end

endmodule

FILE: rtl/core/bse_fifo.sv
module bse_fifo
  import bse_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head_job,
  output logic empty
);

  localparam int PtrW = $clog2(BSE_JOB_DEPTH);
  localparam int CntW = $clog2(BSE_JOB_DEPTH + 1);

  job_t            mem [BSE_JOB_DEPTH];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [CntW-1:0] count_r;

  assign full     = (count_r == CntW'(BSE_JOB_DEPTH));
  assign empty    = (count_r == '0);
  assign head_job = mem[rd_ptr_r];

  // Job storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(BSE_JOB_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(BSE_JOB_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/bse_back.sv
module bse_back
  import bse_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  job_t       head_job,
  input  logic       job_empty,
  output logic       job_pop,
  bse_out_if.source  out_chan
);

  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        run_last_r;
  logic        file_done_r;
  logic [5:0]  idx_r;
  logic [31:0] imagesize_r;
  logic [31:0] filesize_r;

  bpp_t         bpp;
  logic [15:0]  bpp_val;
  logic [8:0]   ncol;
  logic [31:0]  offset;
  logic [18:0]  row_pad;
  logic [34:0]  img_prod;
  logic [495:0] hdr;
  logic [5:0]   last_idx;
  logic         is_last;
  logic         advance;
  logic [7:0]   byte_sel;

  assign bpp = get_bpp(cfg.image_mode, cfg.palette_count);

  // Header fields that depend on the bit depth.
  always_comb begin
    unique case (bpp)
      BPP_1:  begin bpp_val = 16'd1;  ncol = 9'd2; end
      BPP_4:  begin bpp_val = 16'd4;  ncol = cfg.palette_count; end
      BPP_8:  begin bpp_val = 16'd8;  ncol = cfg.palette_count; end
      BPP_24: begin bpp_val = 16'd24; ncol = 9'd0; end
      default: begin bpp_val = 16'd24; ncol = 9'd0; end
    endcase
  end

  assign offset   = 32'd54 + {21'd0, ncol, 2'd0};
  assign row_pad  = (19'(cfg.row_bytes) + 19'd3) & ~19'd3;
  assign img_prod = 35'(row_pad) * 35'(cfg.img_height);

  // Image and file size, refreshed from the registers every cycle.
  always_ff @(posedge clk) begin
    imagesize_r <= img_prod[31:0];
    filesize_r  <= offset + imagesize_r;
  end

  // The header as a little-endian byte string, byte 0 in the low bits.
  assign hdr = {32'h00ff_ffff, 32'd0,
                32'd0, 23'd0, ncol, 32'd3000, 32'd3000, imagesize_r,
                32'd0, bpp_val, 16'd1, 16'd0, cfg.img_height, 16'd0, cfg.img_width,
                32'd40, offset, 16'd0, 16'd0, filesize_r, 8'h4D, 8'h42};

  // Index of the last byte of the job at the head of the queue.
  always_comb begin
    if (head_job.kind == JOB_HEADER) begin
      last_idx = (cfg.image_mode == MODE_MONO && cfg.default_palette) ?
                 HDR_LAST_PAL : HDR_LAST_PLAIN;
    end else begin
      last_idx = 6'(head_job.nbytes) + 6'(head_job.pad) - 6'd1;
    end
  end

  assign is_last = (idx_r == last_idx);

  // Byte selection: header bytes, data bytes, then zero pad.
  always_comb begin
    if (head_job.kind == JOB_HEADER) begin
      byte_sel = hdr[{idx_r, 3'b000} +: 8];
    end else if (idx_r < 6'(head_job.nbytes)) begin
      byte_sel = head_job.data[{idx_r[1:0], 3'b000} +: 8];
    end else begin
      byte_sel = 8'd0;
    end
  end

  assign advance = !out_valid_r || out_chan.ready;
  assign job_pop = advance && !job_empty && is_last;

  // Output register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 6'd0;
    end else if (advance) begin
      out_valid_r <= !job_empty;
      if (!job_empty) begin
        idx_r <= is_last ? 6'd0 : idx_r + 6'd1;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (advance && !job_empty) begin
      out_byte_r  <= byte_sel;
      run_last_r  <= is_last;
      file_done_r <= is_last && (head_job.kind == JOB_DATA) && head_job.done;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.out_byte  = out_byte_r;
  assign out_chan.run_last  = run_last_r;
  assign out_chan.file_done = file_done_r;

endmodule

FILE: rtl/core/bmp_stream_encoder.sv
// BMP stream encoder.
// Input channel in_chan: one transaction per request. A start request emits
// the 54-byte file header (62 bytes in mono mode with the built-in palette),
// a palette request emits four bytes, and a pixel request emits its packed
// pixel bytes followed by the row padding when it closes a row.
// Output channel out_chan: one byte per transaction, with run_last on the
// last byte of each request and file_done on the last byte of the file.
// Configuration: APB write of the six registers at byte addresses 4*i,
// allowed only while the encoder holds no pending work.
// The input transaction is written to the job queue, and the first byte of
// the request then passes through the output register. Throughput is one
// output byte per cycle while the receiver is ready; a request emits 3 bytes
// for a 24-bit pixel (up to 6 with padding), 0 to 4 for other pixels, 4 for
// a palette entry and 54 or 62 for a header. The byte generator is the
// limit; a four-deep job queue lets the input run up to four jobs ahead of it.
// Reset clears the row counters and the queue and restores the register
// defaults. When the receiver stalls, the output byte holds, the queue fills
// and then in_chan.ready drops until the output drains.
module bmp_stream_encoder
  import bse_pkg::*;
#(
  parameter int DIM_BITS = BSE_DIM_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bse_in_if.sink                in_chan,
  bse_out_if.source             out_chan,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [BSE_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t cfg;
  job_t push_job;
  job_t head_job;
  logic job_push;
  logic job_pop;
  logic job_full;
  logic job_empty;

  // Configuration registers.
  bse_regs #(
    .DIM_BITS(DIM_BITS)
  ) u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Request classification and row tracking.
  bse_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_chan  (in_chan),
    .job_full (job_full),
    .job_push (job_push),
    .job      (push_job)
  );

  // Job queue between the two sides.
  bse_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (push_job),
    .full     (job_full),
    .pop      (job_pop),
    .head_job (head_job),
    .empty    (job_empty)
  );

  // Byte generation.
  bse_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .head_job  (head_job),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .out_chan  (out_chan)
  );

endmodule
